[hw/rtl/hsfc_pkg.sv]
`default_nettype none

package hsfc_pkg;

	// CRC-8 as the sensor uses it: polynomial 0x31, seed 0xFF, MSB first, no final XOR.
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// Temperature is scaled by 1750/65535 and offset by 450, humidity by 100/65535.
	localparam logic [10:0] TEMP_SCALE  = 11'd1750;
	localparam logic [11:0] TEMP_OFFSET = 12'd450;
	localparam logic [6:0]  HUM_SCALE   = 7'd100;

	localparam int HSFC_QUEUE_DEPTH = 2;

	// Position of the next byte within a frame.
	typedef enum logic [2:0] {
		POS_HI0   = 3'd0,
		POS_LO0   = 3'd1,
		POS_CRC0  = 3'd2,
		POS_HI1   = 3'd3,
		POS_LO1   = 3'd4,
		POS_CRC1  = 3'd5,
		POS_IDLE  = 3'd7
	} hsfc_pos_t;

	typedef enum logic {
		MODE_MEAS   = 1'b0,
		MODE_STATUS = 1'b1
	} hsfc_mode_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       mode;
		logic       frame_start;
	} hsfc_in_t;

	typedef struct packed {
		logic              result_code;
		logic [15:0]       status_word;
		logic signed [11:0] temperature;
		logic [6:0]        humidity;
	} hsfc_out_t;

	// A finished frame as passed from the byte checker to the conversion stage.
	typedef struct packed {
		logic        fail;
		logic        mode;
		logic [15:0] word_a;
		logic [15:0] word_b;
	} hsfc_frame_t;

	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/humidity_sensor_frame_checker_unit.sv]
// Humidity sensor frame checker. Requests carry one byte of the sensor's reply each, and the
// block takes one request per clock cycle. A frame opens with frame_start, which also latches
// mode: a status frame is three bytes (word high, word low, CRC) and a measurement frame is six
// (two such words). Every word is checked against its CRC-8 byte (polynomial 0x31, seed 0xFF,
// MSB first). On the last byte of a frame one result leaves: result_code 1 on any mismatch with
// all other fields zero, otherwise the status word, or temperature in tenths of a degree and
// relative humidity in whole percent. The result passes through the frame queue and then a
// two-stage conversion pipeline (scaled products, then the finished result) before it appears
// on the output; bytes keep flowing in while results wait, and the input stalls only when the
// two-entry frame queue in front of the conversion pipeline is full.
`default_nettype none

module humidity_sensor_frame_checker_unit
	import hsfc_pkg::*;
#(
	parameter int QUEUE_DEPTH = HSFC_QUEUE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire hsfc_in_t  in_req,
	output logic           out_valid,
	input  wire logic      out_ready,
	output hsfc_out_t      out_res
);

	// Finished frames travel from the byte checker to the conversion pipeline.
	logic        push_valid;
	hsfc_frame_t push_data;
	logic        queue_full;
	logic        pop_valid;
	logic        pop_ready;
	hsfc_frame_t pop_data;

	// The front end runs the CRC and assembles words, one byte per cycle while the queue has room.
	hsfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_req     (in_req),
		.push_valid (push_valid),
		.push_data  (push_data),
		.queue_full (queue_full)
	);

	// The queue lets the front end run on while the output side is held up.
	hsfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (queue_full),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// The back end scales the words and divides by 65535 without a divider.
	hsfc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (pop_valid),
		.frame_ready (pop_ready),
		.frame_data  (pop_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_res     (out_res)
	);

endmodule

`default_nettype wire

[hw/rtl/hsfc_front.sv]
`default_nettype none

module hsfc_front
	import hsfc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire hsfc_in_t    in_req,
	output logic             push_valid,
	output hsfc_frame_t      push_data,
	input  wire logic        queue_full
);

	hsfc_pos_t   pos_q;
	logic [7:0]  crc_q;
	logic [15:0] word_q;
	logic [15:0] first_q;
	logic        mode_q;
	logic        fail_q;

	hsfc_pos_t   pos_d;
	logic [7:0]  crc_d;
	logic [15:0] word_d;
	logic [15:0] first_d;
	logic        mode_d;
	logic        fail_d;

	hsfc_pos_t   pos_cur;
	logic        fail_cur;
	logic        mode_cur;
	logic [7:0]  crc_cur;
	logic        fail_chk;
	hsfc_pos_t   pos_last;
	logic        accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		// A frame start restarts the frame before the byte is looked at.
		pos_cur  = in_req.frame_start ? POS_HI0 : pos_q;
		crc_cur  = in_req.frame_start ? CRC_INIT : crc_q;
		fail_cur = in_req.frame_start ? 1'b0 : fail_q;
		mode_cur = in_req.frame_start ? in_req.mode : mode_q;
		pos_last = (mode_cur == MODE_STATUS) ? POS_CRC0 : POS_CRC1;
		fail_chk = fail_cur || (crc_cur != in_req.data_byte);

		pos_d      = pos_cur;
		crc_d      = crc_cur;
		word_d     = word_q;
		first_d    = first_q;
		mode_d     = mode_cur;
		fail_d     = fail_cur;
		push_valid = 1'b0;
		push_data  = '{fail: fail_chk, mode: mode_cur,
			word_a: (pos_cur == POS_CRC0) ? word_q : first_q, word_b: word_q};

		case (pos_cur)
			POS_HI0, POS_HI1: begin
				crc_d  = crc_byte(crc_cur, in_req.data_byte);
				word_d = {in_req.data_byte, 8'h00};
				pos_d  = hsfc_pos_t'(pos_cur + 3'd1);
			end
			POS_LO0, POS_LO1: begin
				crc_d  = crc_byte(crc_cur, in_req.data_byte);
				word_d = {word_q[15:8], in_req.data_byte};
				pos_d  = hsfc_pos_t'(pos_cur + 3'd1);
			end
			POS_CRC0, POS_CRC1: begin
				fail_d = fail_chk;
				crc_d  = CRC_INIT;
				if (pos_cur == POS_CRC0) begin
					first_d = word_q;
				end
				if (pos_cur == pos_last) begin
					pos_d      = POS_IDLE;
					push_valid = accept;
				end else begin
					pos_d = hsfc_pos_t'(pos_cur + 3'd1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_HI0;
			crc_q   <= CRC_INIT;
			word_q  <= '0;
			first_q <= '0;
			mode_q  <= MODE_MEAS;
			fail_q  <= 1'b0;
		end else if (accept) begin
			pos_q   <= pos_d;
			crc_q   <= crc_d;
			word_q  <= word_d;
			first_q <= first_d;
			mode_q  <= mode_d;
			fail_q  <= fail_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/hsfc_queue.sv]
`default_nettype none

module hsfc_queue
	import hsfc_pkg::*;
#(
	parameter int DEPTH = HSFC_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push_valid,
	input  wire hsfc_frame_t push_data,
	output logic             full,
	output logic             pop_valid,
	input  wire logic        pop_ready,
	output hsfc_frame_t      pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	hsfc_frame_t      entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/hsfc_back.sv]
`default_nettype none

module hsfc_back
	import hsfc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        frame_valid,
	output logic             frame_ready,
	input  wire hsfc_frame_t frame_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output hsfc_out_t        out_res
);

	// Stage one holds the scaled products, stage two the finished result.
	logic        valid_s1;
	logic        fail_s1;
	logic        mode_s1;
	logic [15:0] status_s1;
	logic [26:0] prod_t_s1;
	logic [22:0] prod_h_s1;

	logic        valid_q;
	hsfc_out_t   res_q;

	logic        load_out;
	logic        load_s1;
	logic [27:0] sum_t;
	logic [23:0] sum_h;
	logic [10:0] quot_t;
	logic [6:0]  quot_h;
	hsfc_out_t   res_d;

	assign load_out    = !valid_q || out_ready;
	assign load_s1     = !valid_s1 || load_out;
	assign frame_ready = load_s1;
	assign out_valid   = valid_q;
	assign out_res     = res_q;

	// Division by 65535 for a dividend below 2^32 - 1: (x + (x >> 16) + 1) >> 16.
	always_comb begin
		sum_t  = 28'(prod_t_s1) + 28'(prod_t_s1[26:16]) + 28'd1;
		sum_h  = 24'(prod_h_s1) + 24'(prod_h_s1[22:16]) + 24'd1;
		quot_t = sum_t[26:16];
		quot_h = sum_h[22:16];

		res_d = '{result_code: fail_s1, status_word: '0, temperature: '0, humidity: '0};
		if (!fail_s1) begin
			if (mode_s1 == MODE_STATUS) begin
				res_d.status_word = status_s1;
			end else begin
				res_d.temperature = $signed(12'(quot_t) - TEMP_OFFSET);
				res_d.humidity    = quot_h;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			fail_s1   <= frame_data.fail;
			mode_s1   <= frame_data.mode;
			status_s1 <= frame_data.word_a;
			prod_t_s1 <= 27'(frame_data.word_a) * 27'(TEMP_SCALE);
			prod_h_s1 <= 23'(frame_data.word_b) * 23'(HUM_SCALE);
		end
		if (load_out) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= frame_valid;
			end
			if (load_out) begin
				valid_q <= valid_s1;
			end
		end
	end

endmodule

`default_nettype wire

[bench/hsfc_reading_monitor.sv]
`default_nettype none

module hsfc_reading_monitor
	import hsfc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_ready,
	input  wire hsfc_in_t  in_req,
	input  wire logic      out_valid,
	input  wire logic      out_ready,
	input  wire hsfc_out_t out_res,
	output int             failures,
	output int             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Running copy of the frame decoder.
	hsfc_pos_t   next_pos;
	hsfc_mode_t  cur_mode;
	logic [7:0]  word_crc;
	logic [15:0] word_acc;
	logic [15:0] saved_word;
	logic        bad_check;

	hsfc_out_t readings_due[$];

	// Bit-serial form of the CRC-8 register update.
	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] r;
		r = crc;
		for (int k = 7; k >= 0; k--) begin
			if (r[7] ^ b[k]) begin
				r = {r[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[6:0], 1'b0};
			end
		end
		return r;
	endfunction

	task automatic absorb_byte(input hsfc_in_t req);
		hsfc_out_t   res;
		int unsigned tenths;
		int unsigned percent;
		if (req.frame_start) begin
			next_pos  = POS_HI0;
			word_crc  = CRC_INIT;
			bad_check = 1'b0;
			cur_mode  = hsfc_mode_t'(req.mode);
		end
		case (next_pos)
			POS_HI0, POS_HI1: begin
				word_crc = crc8_next(word_crc, req.data_byte);
				word_acc = {req.data_byte, 8'h00};
				next_pos = (next_pos == POS_HI0) ? POS_LO0 : POS_LO1;
			end
			POS_LO0, POS_LO1: begin
				word_crc = crc8_next(word_crc, req.data_byte);
				word_acc[7:0] = req.data_byte;
				next_pos = (next_pos == POS_LO0) ? POS_CRC0 : POS_CRC1;
			end
			POS_CRC0, POS_CRC1: begin
				if (word_crc != req.data_byte) begin
					bad_check = 1'b1;
				end
				word_crc = CRC_INIT;
				if (next_pos == POS_CRC0) begin
					saved_word = word_acc;
				end
				if (next_pos == POS_CRC0 && cur_mode == MODE_MEAS) begin
					next_pos = POS_HI1;
				end else begin
					next_pos = POS_IDLE;
					res = '0;
					res.result_code = bad_check;
					if (!bad_check) begin
						if (cur_mode == MODE_STATUS) begin
							res.status_word = saved_word;
						end else begin
							tenths  = (32'd1750 * saved_word) / 32'd65535;
							percent = (32'd100 * word_acc) / 32'd65535;
							res.temperature = 12'(tenths - 32'd450);
							res.humidity    = 7'(percent);
						end
					end
					readings_due.push_back(res);
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		hsfc_out_t want;
		if (!arst_n) begin
			next_pos   = POS_HI0;
			cur_mode   = MODE_MEAS;
			word_crc   = CRC_INIT;
			word_acc   = '0;
			saved_word = '0;
			bad_check  = 1'b0;
			readings_due.delete();
			failures   = 0;
			pending    = 0;
		end else begin
			if (in_valid && in_ready) begin
				absorb_byte(in_req);
			end
			if (out_valid && out_ready) begin
				if (readings_due.size() == 0) begin
					$display("%0t: unexpected result, got %p", $time, out_res);
					failures++;
				end else begin
					want = readings_due.pop_front();
					if (out_res.result_code !== want.result_code) begin
						$display("%0t: result_code expected %0d got %0d", $time,
							want.result_code, out_res.result_code);
						failures++;
					end
					if (out_res.status_word !== want.status_word) begin
						$display("%0t: status_word expected %h got %h", $time,
							want.status_word, out_res.status_word);
						failures++;
					end
					if (out_res.temperature !== want.temperature) begin
						$display("%0t: temperature expected %0d got %0d", $time,
							want.temperature, out_res.temperature);
						failures++;
					end
					if (out_res.humidity !== want.humidity) begin
						$display("%0t: humidity expected %0d got %0d", $time,
							want.humidity, out_res.humidity);
						failures++;
					end
				end
			end
			pending = readings_due.size();
		end
	end

endmodule

`default_nettype wire

[bench/tb_top.sv]
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hsfc_pkg::*;

	// Roughly this many requests make up the random part of the run.
	localparam int RANDOM_BYTES = 1550;
	// Far beyond the slowest legal run, long receiver hold-off included.
	localparam int CYCLE_LIMIT  = 300000;
	// Cycles allowed after the last expected result for anything stray to turn up.
	localparam int DRAIN_CYCLES = 20;
	// Length of the one guaranteed receiver hold-off, long enough to back the block up.
	localparam int LONG_HOLD    = 400;

	// How the result side behaves over one stretch of cycles.
	typedef enum int {
		RX_OPEN,
		RX_HALF,
		RX_SPARSE,
		RX_HOLD
	} rx_style_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	hsfc_in_t  in_req;
	logic      out_valid;
	logic      out_ready;
	hsfc_out_t out_res;

	int failures;
	int pending;
	int cycle_count = 0;
	int items_sent = 0;
	int burst_left = 0;
	bit random_phase = 1'b0;
	bit held_once = 1'b0;

	humidity_sensor_frame_checker_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	// The monitor watches both channels, predicts every reading and counts mismatches.
	hsfc_reading_monitor mon (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res),
		.failures  (failures),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here rather than never.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side. It runs through stretches of differing willingness, from always
	// ready down to flat refusal. Once the random part begins it first refuses for a
	// long stretch, so that the frame queue fills and the block has to stall its input
	// whilst the sender keeps offering requests.
	initial begin : receiver
		rx_style_t style;
		int stretch;
		style   = RX_OPEN;
		stretch = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stretch == 0) begin
				if (random_phase && !held_once) begin
					held_once = 1'b1;
					style     = RX_HOLD;
					stretch   = LONG_HOLD;
				end else begin
					case ($urandom_range(0, 9))
						0, 1, 2: style = RX_OPEN;
						3, 4, 5: style = RX_HALF;
						6, 7, 8: style = RX_SPARSE;
						default: style = RX_HOLD;
					endcase
					stretch = (style == RX_HOLD) ? $urandom_range(20, 120)
						: $urandom_range(5, 80);
				end
			end
			stretch--;
			case (style)
				RX_OPEN:   out_ready <= 1'b1;
				RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default:   out_ready <= 1'b0;
			endcase
		end
	end

	// Check byte for a word as the sensor would append it, worked out bit by bit
	// over the whole 16-bit word.
	function automatic logic [7:0] word_check(input logic [15:0] w);
		logic [7:0] r;
		r = CRC_INIT;
		for (int k = 15; k >= 0; k--) begin
			if (r[7] ^ w[k]) begin
				r = {r[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[6:0], 1'b0};
			end
		end
		return r;
	endfunction

	// Word values lean towards the two ends of the range, where the conversions
	// reach their limits.
	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Offers one request and waits for the edge that takes it. The ready line is
	// looked at on the falling edge, where it has settled. Requests go out in bursts;
	// when a burst runs out, valid is dropped for a random gap and a new burst length
	// is drawn, now and then a long one so that stretches without idling occur.
	task automatic offer(input logic [7:0] b, input logic m, input logic s, input bit counted);
		in_req   <= {b, m, s};
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
		end while (!in_ready);
		@(posedge clk);
		if (counted) begin
			items_sent++;
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(0, 20);
		end
	endtask

	// One word, its high byte first, then its check byte, spoilt on request. The mode
	// bit on the bytes after the first is random, as the block must disregard it there.
	task automatic send_word(input logic [15:0] w, input logic s, input logic m,
			input bit spoil);
		logic [7:0] chk;
		chk = word_check(w);
		if (spoil) begin
			chk = chk ^ 8'($urandom_range(1, 255));
		end
		offer(w[15:8], m, s, 1'b1);
		offer(w[7:0], 1'($urandom_range(0, 1)), 1'b0, 1'b1);
		offer(chk, 1'($urandom_range(0, 1)), 1'b0, 1'b1);
	endtask

	task automatic send_frame(input hsfc_mode_t m, input logic s, input logic [15:0] wa,
			input logic [15:0] wb, input bit spoil_a, input bit spoil_b);
		send_word(wa, s, m, spoil_a);
		if (m == MODE_MEAS) begin
			send_word(wb, 1'b0, m, spoil_b);
		end
	endtask

	initial begin : stimulus
		hsfc_mode_t m;
		int pick;
		int cut;
		int frame_len;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_req   = '0;
		burst_left = $urandom_range(0, 20);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight out of reset, with no frame start: read as a measurement frame.
		// Both words at zero give the coldest and driest reading.
		send_frame(MODE_MEAS, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0);
		// A stray byte once the frame is over must be ignored.
		offer(8'hFF, MODE_STATUS, 1'b0, 1'b0);
		// Status frame with every bit set.
		send_frame(MODE_STATUS, 1'b1, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
		// Both words at full scale give the hottest and wettest reading.
		send_frame(MODE_MEAS, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
		// Status frame whose check byte is wrong: failure with every field zero.
		send_frame(MODE_STATUS, 1'b1, 16'h8001, 16'h0000, 1'b1, 1'b0);
		// A measurement frame cut short by a fresh frame start, which must restart
		// the decoder cleanly and drop the unfinished frame.
		offer(8'h12, MODE_MEAS, 1'b1, 1'b1);
		offer(8'h34, MODE_MEAS, 1'b0, 1'b1);
		send_frame(MODE_STATUS, 1'b1, 16'h0001, 16'h0000, 1'b0, 1'b0);

		// Random part: mostly well-formed frames with random words, a few with bad
		// check bytes, mixed with frames cut short, loose bytes and trailing junk.
		random_phase = 1'b1;
		items_sent   = 0;
		while (items_sent < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			m    = hsfc_mode_t'($urandom_range(0, 1));
			if (pick < 70) begin
				send_frame(m, 1'b1, pick_word(), pick_word(),
					$urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0);
			end else if (pick < 82) begin
				frame_len = (m == MODE_MEAS) ? 6 : 3;
				cut = $urandom_range(1, frame_len - 1);
				offer(8'($urandom_range(0, 255)), m, 1'b1, 1'b1);
				for (int k = 1; k < cut; k++) begin
					offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 1'b1);
				end
			end else if (pick < 92) begin
				offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					$urandom_range(0, 3) == 0, 1'b1);
			end else begin
				offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
			end
		end

		// Nothing more to offer: drop valid unless the last gap already did.
		if (in_valid) begin
			in_valid <= 1'b0;
		end
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
